// ===== rtl/bcht_pkg.sv =====
// ----------------------------------------------------------------------------
// bcht_pkg
// Shared codes, hash constants and the integer mix step of the hash table.
// ----------------------------------------------------------------------------
package bcht_pkg;

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_GET    = 2'd1;
  localparam logic [1:0] FN_REMOVE = 2'd2;
  localparam logic [1:0] FN_UPDATE = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_DUPLICATE = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic [31:0] MIX_C0 = 32'h7ed55d16;
  localparam logic [31:0] MIX_C1 = 32'hc761c23c;
  localparam logic [31:0] MIX_C2 = 32'h165667b1;
  localparam logic [31:0] MIX_C3 = 32'hd3a2646c;
  localparam logic [31:0] MIX_C4 = 32'hfd7046c5;
  localparam logic [31:0] MIX_C5 = 32'hb55a4f09;

  localparam logic [2:0] MIX_LAST = 3'd5;

  // One round of the six-round integer mix; idx selects the round.
  function automatic logic [31:0] mix_step(input logic [31:0] h, input logic [2:0] idx);
    logic [31:0] r;
    case (idx)
      3'd0:    r = (h + MIX_C0) + (h << 12);
      3'd1:    r = (h ^ MIX_C1) ^ (h >> 19);
      3'd2:    r = (h + MIX_C2) + (h << 5);
      3'd3:    r = (h + MIX_C3) ^ (h << 9);
      3'd4:    r = (h + MIX_C4) + (h << 3);
      default: r = (h ^ MIX_C5) ^ (h >> 16);
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/bcht_ram.sv =====
// ----------------------------------------------------------------------------
// bcht_ram
// Generic simple dual-port RAM: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bcht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bcht_fifo.sv =====
// ----------------------------------------------------------------------------
// bcht_fifo
// Two-entry show-ahead queue between the front and the back of the table.
// ----------------------------------------------------------------------------
module bcht_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wptr] <= wdata;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr && !full) begin
        wptr <= ~wptr;
      end
      if (rd && !empty) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(wr && !full) - 2'(rd && !empty);
    end
  end

endmodule

// ===== rtl/bcht_front.sv =====
// ----------------------------------------------------------------------------
// bcht_front
// Takes one request, runs the integer mix one round a cycle, then reduces the
// hash modulo the bucket count by a reciprocal multiply and queues the item.
// ----------------------------------------------------------------------------
module bcht_front
  import bcht_pkg::*;
#(
  parameter int NUM_BANK_TABLES  = 8,
  parameter int BUCKETS_PER_BANK = 1024,
  parameter int BW  = (NUM_BANK_TABLES > 1) ? $clog2(NUM_BANK_TABLES) : 1,
  parameter int HAW = $clog2(NUM_BANK_TABLES * BUCKETS_PER_BANK)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           clearing,
  input  logic           push,
  output logic           full,
  input  logic [1:0]     func,
  input  logic [2:0]     bank,
  input  logic [31:0]    key,
  input  logic [11:0]    value_in,
  output logic           q_wr,
  input  logic           q_full,
  output logic [1:0]     q_func,
  output logic           q_ok,
  output logic [BW-1:0]  q_bank,
  output logic [31:0]    q_key,
  output logic [11:0]    q_val,
  output logic [HAW-1:0] q_slot
);

  localparam int RW = $clog2(BUCKETS_PER_BANK);
  localparam logic [31:0] MOD_M = 32'(64'h1_0000_0000 / 64'(BUCKETS_PER_BANK));
  localparam logic [16:0] MOD_B = 17'(BUCKETS_PER_BANK);

  typedef enum logic [2:0] {F_IDLE, F_HASH, F_MUL, F_QB, F_SUB, F_PUSH} fstate_t;

  fstate_t       state;
  logic [31:0]   h;
  logic [2:0]    cnt;
  logic [31:0]   q0;
  logic [31:0]   qb;
  logic [31:0]   r0;
  logic [RW-1:0] rem;

  assign full  = (state != F_IDLE) || clearing;
  assign q_wr  = (state == F_PUSH);
  assign r0    = h - qb;
  assign q_slot = HAW'(32'(q_bank) * 32'(BUCKETS_PER_BANK) + 32'(rem));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (push && !full) begin
            q_func <= func;
            q_key  <= key;
            q_val  <= value_in;
            q_ok   <= (32'(bank) < 32'(NUM_BANK_TABLES));
            q_bank <= (32'(bank) < 32'(NUM_BANK_TABLES)) ? BW'(bank) : '0;
            h      <= key;
            cnt    <= 3'd0;
            state  <= F_HASH;
          end
        end
        F_HASH: begin
          h <= mix_step(h, cnt);
          if (cnt == MIX_LAST) begin
            state <= F_MUL;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        F_MUL: begin
          // The truncated reciprocal gives a quotient at most one too small.
          q0    <= 32'((64'(h) * 64'(MOD_M)) >> 32);
          state <= F_QB;
        end
        F_QB: begin
          qb    <= 32'(64'(q0) * 64'(MOD_B));
          state <= F_SUB;
        end
        F_SUB: begin
          // The partial remainder stays below twice the count.
          if (r0 >= 32'(BUCKETS_PER_BANK)) begin
            rem <= RW'(r0 - 32'(BUCKETS_PER_BANK));
          end else begin
            rem <= RW'(r0);
          end
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== rtl/bcht_back.sv =====
// ----------------------------------------------------------------------------
// bcht_back
// Walks the bucket chain in node memory and carries out insert, get, remove
// and update; owns the free lists, the slot counters and the result register.
// ----------------------------------------------------------------------------
module bcht_back
  import bcht_pkg::*;
#(
  parameter int NUM_BANK_TABLES  = 8,
  parameter int BUCKETS_PER_BANK = 1024,
  parameter int NODES_PER_BANK   = 4096,
  parameter int BW  = (NUM_BANK_TABLES > 1) ? $clog2(NUM_BANK_TABLES) : 1,
  parameter int HAW = $clog2(NUM_BANK_TABLES * BUCKETS_PER_BANK)
) (
  input  logic           clk,
  input  logic           rst,
  output logic           clearing,
  input  logic           q_empty,
  output logic           q_rd,
  input  logic [1:0]     q_func,
  input  logic           q_ok,
  input  logic [BW-1:0]  q_bank,
  input  logic [31:0]    q_key,
  input  logic [11:0]    q_val,
  input  logic [HAW-1:0] q_slot,
  input  logic           pop,
  output logic           empty,
  output logic [1:0]     status,
  output logic [11:0]    value_out
);

  localparam int PW    = $clog2(NODES_PER_BANK + 1);
  localparam int NDEP  = NUM_BANK_TABLES * NODES_PER_BANK;
  localparam int NAW   = $clog2(NDEP);
  localparam int HDEP  = NUM_BANK_TABLES * BUCKETS_PER_BANK;
  localparam logic [PW-1:0]  NODES   = PW'(NODES_PER_BANK);
  localparam logic [HAW-1:0] CLR_END = HAW'(HDEP - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HEAD, S_WALK, S_NODE, S_ACT, S_FREE, S_INS, S_REM2, S_OUT
  } bstate_t;

  bstate_t        state;
  logic [HAW-1:0] clr;
  logic [1:0]     it_func;
  logic [BW-1:0]  it_bank;
  logic [31:0]    it_key;
  logic [11:0]    it_val;
  logic [HAW-1:0] it_slot;
  logic [PW-1:0]  head_val, cur, prev, steps, hit, hit_link, newp;
  logic [11:0]    hit_val;
  logic [PW-1:0]  free_head [NUM_BANK_TABLES];
  logic [PW-1:0]  used [NUM_BANK_TABLES];
  logic [1:0]     res_status;
  logic [11:0]    res_val;
  logic           out_valid;

  logic [PW-1:0]  fh, uc;
  logic [PW-1:0]  node_ptr;
  logic [NAW-1:0] naddr;
  logic           head_we;
  logic [HAW-1:0] head_waddr;
  logic [PW-1:0]  head_wdata, head_rdata;
  logic           key_we, val_we, link_we;
  logic [11:0]    val_wdata, val_rdata;
  logic [PW-1:0]  link_wdata, link_rdata;
  logic [31:0]    key_rdata;

  assign clearing  = (state == S_CLEAR);
  assign q_rd      = (state == S_IDLE) && !q_empty;
  assign empty     = !out_valid;
  assign fh        = free_head[it_bank];
  assign uc        = used[it_bank];
  assign naddr     = NAW'(32'(it_bank) * 32'(NODES_PER_BANK) + 32'(node_ptr) - 32'd1);

  always_comb begin
    node_ptr   = hit;
    head_we    = 1'b0;
    head_waddr = it_slot;
    head_wdata = '0;
    key_we     = 1'b0;
    val_we     = 1'b0;
    link_we    = 1'b0;
    val_wdata  = it_val;
    link_wdata = head_val;
    unique case (state)
      S_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr;
      end
      S_WALK: node_ptr = cur;
      S_ACT: begin
        if (it_func == FN_INSERT) begin
          node_ptr = fh;
        end else if (it_func == FN_REMOVE) begin
          node_ptr = prev;
          if (hit != '0) begin
            if (prev != '0) begin
              link_we    = 1'b1;
              link_wdata = hit_link;
            end else begin
              head_we    = 1'b1;
              head_wdata = hit_link;
            end
          end
        end else if (it_func == FN_UPDATE) begin
          val_we = (hit != '0);
        end
      end
      S_INS: begin
        node_ptr   = newp;
        key_we     = 1'b1;
        val_we     = 1'b1;
        link_we    = 1'b1;
        head_we    = 1'b1;
        head_wdata = newp;
      end
      S_REM2: begin
        link_we    = 1'b1;
        link_wdata = fh;
      end
      default: ;
    endcase
  end

  bcht_ram #(.WIDTH(PW), .DEPTH(HDEP)) u_heads (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(q_slot), .rdata(head_rdata)
  );

  bcht_ram #(.WIDTH(32), .DEPTH(NDEP)) u_keys (
    .clk(clk), .we(key_we), .waddr(naddr), .wdata(it_key),
    .raddr(naddr), .rdata(key_rdata)
  );

  bcht_ram #(.WIDTH(12), .DEPTH(NDEP)) u_values (
    .clk(clk), .we(val_we), .waddr(naddr), .wdata(val_wdata),
    .raddr(naddr), .rdata(val_rdata)
  );

  bcht_ram #(.WIDTH(PW), .DEPTH(NDEP)) u_links (
    .clk(clk), .we(link_we), .waddr(naddr), .wdata(link_wdata),
    .raddr(naddr), .rdata(link_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_BANK_TABLES; i++) begin
        free_head[i] <= '0;
        used[i]      <= '0;
      end
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + HAW'(1);
          if (clr == CLR_END) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            it_func    <= q_func;
            it_bank    <= q_bank;
            it_key     <= q_key;
            it_val     <= q_val;
            it_slot    <= q_slot;
            res_status <= ST_NOT_FOUND;
            res_val    <= '0;
            state      <= q_ok ? S_HEAD : S_OUT;
          end
        end
        S_HEAD: begin
          head_val <= head_rdata;
          cur      <= head_rdata;
          prev     <= '0;
          steps    <= '0;
          state    <= S_WALK;
        end
        S_WALK: begin
          if (cur == '0 || cur > NODES || steps == NODES) begin
            hit   <= '0;
            state <= S_ACT;
          end else begin
            state <= S_NODE;
          end
        end
        S_NODE: begin
          if (key_rdata == it_key) begin
            hit      <= cur;
            hit_link <= link_rdata;
            hit_val  <= val_rdata;
            state    <= S_ACT;
          end else begin
            prev  <= cur;
            cur   <= link_rdata;
            steps <= steps + PW'(1);
            state <= S_WALK;
          end
        end
        S_ACT: begin
          state <= S_OUT;
          unique case (it_func)
            FN_INSERT: begin
              if (hit != '0) begin
                res_status <= ST_DUPLICATE;
              end else if (fh != '0 && fh <= NODES) begin
                newp  <= fh;
                state <= S_FREE;
              end else if (uc < NODES) begin
                used[it_bank] <= uc + PW'(1);
                newp          <= uc + PW'(1);
                state         <= S_INS;
              end else begin
                res_status <= ST_FULL;
              end
            end
            FN_GET: begin
              if (hit != '0) begin
                res_status <= ST_OK;
                res_val    <= hit_val;
              end
            end
            FN_REMOVE: begin
              if (hit != '0) begin
                state <= S_REM2;
              end
            end
            FN_UPDATE: begin
              if (hit != '0) begin
                res_status <= ST_OK;
              end
            end
          endcase
        end
        S_FREE: begin
          free_head[it_bank] <= link_rdata;
          state              <= S_INS;
        end
        S_INS: begin
          res_status <= ST_OK;
          state      <= S_OUT;
        end
        S_REM2: begin
          free_head[it_bank] <= hit;
          res_status         <= ST_OK;
          state              <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            status    <= res_status;
            value_out <= res_val;
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !q_rd) else $error("queue read during head clear");

  a_insert_ptr: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS) |-> (newp != '0 && newp <= NODES)) else $error("bad insert node");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_NODE) |-> (steps < NODES)) else $error("chain walk beyond bound");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> out_valid) else $error("result lost while waiting");

endmodule

// ===== rtl/banked_chained_hash_table.sv =====
// ----------------------------------------------------------------------------
// banked_chained_hash_table
// Per-bank key-to-value hash table with chained buckets and node free lists.
// ----------------------------------------------------------------------------
// Requests enter as a queue: a beat is taken when push is high and full low.
// Each beat carries func (insert, get, remove, update), bank, key, value_in.
// Results leave as a queue: status and value_out are valid while empty is
// low, and the beat is taken when pop is high and empty low. One result per
// request, in request order.
// The front takes one request at a time: a capture, six mix rounds, three
// steps of reciprocal-multiply bucket reduction and a push into a two-entry
// queue. The back reads the bucket head, takes a walk and a node step per
// chain node visited and then acts, adding insert steps for an insert or a
// second step for a remove; its node memories read and write at one shared
// address. Front and back overlap; longer chains make the back the limit.
// After reset the bucket heads are cleared one entry a cycle, all
// NUM_BANK_TABLES * BUCKETS_PER_BANK of them; full stays high meanwhile.
// When the receiver stalls, one result waits in the output register, one
// more request can finish in the back, and the queue and front then fill.
// ----------------------------------------------------------------------------
module banked_chained_hash_table
  import bcht_pkg::*;
#(
  parameter int NUM_BANK_TABLES  = 8,
  parameter int BUCKETS_PER_BANK = 1024,
  parameter int NODES_PER_BANK   = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  func,
  input  logic [2:0]  bank,
  input  logic [31:0] key,
  input  logic [11:0] value_in,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [11:0] value_out
);

  localparam int BW  = (NUM_BANK_TABLES > 1) ? $clog2(NUM_BANK_TABLES) : 1;
  localparam int HAW = $clog2(NUM_BANK_TABLES * BUCKETS_PER_BANK);
  localparam int IW  = 2 + 1 + BW + 32 + 12 + HAW;

  logic           clearing;
  logic           f_wr, q_full, q_empty, q_rd;
  logic [1:0]     f_func, b_func;
  logic           f_ok, b_ok;
  logic [BW-1:0]  f_bank, b_bank;
  logic [31:0]    f_key, b_key;
  logic [11:0]    f_val, b_val;
  logic [HAW-1:0] f_slot, b_slot;
  logic [IW-1:0]  q_wdata, q_rdata;

  bcht_front #(
    .NUM_BANK_TABLES(NUM_BANK_TABLES), .BUCKETS_PER_BANK(BUCKETS_PER_BANK),
    .BW(BW), .HAW(HAW)
  ) u_front (
    .clk(clk), .rst(rst), .clearing(clearing), .push(push), .full(full),
    .func(func), .bank(bank), .key(key), .value_in(value_in),
    .q_wr(f_wr), .q_full(q_full), .q_func(f_func), .q_ok(f_ok),
    .q_bank(f_bank), .q_key(f_key), .q_val(f_val), .q_slot(f_slot)
  );

  assign q_wdata = {f_func, f_ok, f_bank, f_key, f_val, f_slot};
  assign {b_func, b_ok, b_bank, b_key, b_val, b_slot} = q_rdata;

  bcht_fifo #(.WIDTH(IW)) u_queue (
    .clk(clk), .rst(rst), .wr(f_wr), .wdata(q_wdata), .full(q_full),
    .rd(q_rd), .rdata(q_rdata), .empty(q_empty)
  );

  bcht_back #(
    .NUM_BANK_TABLES(NUM_BANK_TABLES), .BUCKETS_PER_BANK(BUCKETS_PER_BANK),
    .NODES_PER_BANK(NODES_PER_BANK), .BW(BW), .HAW(HAW)
  ) u_back (
    .clk(clk), .rst(rst), .clearing(clearing), .q_empty(q_empty), .q_rd(q_rd),
    .q_func(b_func), .q_ok(b_ok), .q_bank(b_bank), .q_key(b_key),
    .q_val(b_val), .q_slot(b_slot), .pop(pop), .empty(empty),
    .status(status), .value_out(value_out)
  );

endmodule
